// ===== rtl/joystick_to_mouse_motion_macros.svh =====
// Assertion macros shared by the joystick to mouse motion RTL.
`ifndef JOYSTICK_TO_MOUSE_MOTION_MACROS_SVH
`define JOYSTICK_TO_MOUSE_MOTION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define J2M_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define J2M_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/j2m_pkg.sv =====
// Shared types and constants for the joystick to mouse motion block.
`timescale 1ns / 1ps

package j2m_pkg;

    localparam int J2M_ADC_MAX  = 1023;
    localparam int J2M_TIME_W   = 32;
    localparam int J2M_SAMPLE_W = 10;
    localparam int J2M_SENS_W   = 10;
    localparam int J2M_DZ_W     = 9;
    localparam int J2M_MS_W     = 7;
    localparam int J2M_SDIV_W   = 8;
    localparam int J2M_ACCEL_W  = 11;
    localparam int J2M_MSEC_W   = 16;
    localparam int J2M_STEP_W   = 8;
    localparam int J2M_REPS_W   = 8;
    localparam int J2M_FRAC_W   = 8;
    localparam int J2M_LIM_W    = J2M_MS_W + J2M_FRAC_W;
    localparam int J2M_CIDX_W   = 3;
    localparam int J2M_CDATA_W  = 16;

    localparam logic [J2M_REPS_W-1:0] J2M_REPS_MAX = '1;

    typedef enum logic [J2M_CIDX_W-1:0] {
        REG_SENSITIVITY    = 3'd0,
        REG_DEAD_ZONE      = 3'd1,
        REG_MAX_SPEED      = 3'd2,
        REG_SPEED_DIVISOR  = 3'd3,
        REG_ACCEL_BASE     = 3'd4,
        REG_REPEAT_INTERVAL = 3'd5,
        REG_FIRST_DELAY    = 3'd6,
        REG_DEBOUNCE       = 3'd7
    } j2m_reg_e;

    typedef struct packed {
        logic [J2M_SENS_W-1:0]  sensitivity;
        logic [J2M_DZ_W-1:0]    dead_zone;
        logic [J2M_MS_W-1:0]    max_speed;
        logic [J2M_SDIV_W-1:0]  speed_divisor;
        logic [J2M_ACCEL_W-1:0] accel_base;
        logic [J2M_MSEC_W-1:0]  repeat_interval_ms;
        logic [J2M_MSEC_W-1:0]  first_delay_ms;
        logic [J2M_MSEC_W-1:0]  debounce_ms;
    } j2m_cfg_t;

    localparam j2m_cfg_t J2M_CFG_RESET = '{
        sensitivity:        10'd100,
        dead_zone:          9'd5,
        max_speed:          7'd10,
        speed_divisor:      8'd1,
        accel_base:         11'd307,
        repeat_interval_ms: 16'd50,
        first_delay_ms:     16'd300,
        debounce_ms:        16'd5
    };

    typedef struct packed {
        logic                  start;
        logic [J2M_REPS_W-1:0] reps;
    } j2m_lane_req_t;

    typedef struct packed {
        logic                         done;
        logic                         nonzero;
        logic signed [J2M_STEP_W-1:0] step;
    } j2m_lane_res_t;

endpackage

// ===== rtl/j2m_intf.sv =====
// Handshake interfaces for the stick, report and configuration channels.
`timescale 1ns / 1ps

interface j2m_stick_if
    import j2m_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [J2M_TIME_W-1:0]   now_ms;
    logic [J2M_SAMPLE_W-1:0] x_sample;
    logic [J2M_SAMPLE_W-1:0] y_sample;
    logic                    button_level;

    modport source (output valid, now_ms, x_sample, y_sample, button_level, input ready);
    modport sink (input valid, now_ms, x_sample, y_sample, button_level, output ready);
endinterface

interface j2m_report_if
    import j2m_pkg::*;
();
    logic                         valid;
    logic                         ready;
    logic                         button_bit;
    logic signed [J2M_STEP_W-1:0] dx;
    logic signed [J2M_STEP_W-1:0] dy;

    modport source (output valid, button_bit, dx, dy, input ready);
    modport sink (input valid, button_bit, dx, dy, output ready);
endinterface

interface j2m_cfg_if
    import j2m_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [J2M_CIDX_W-1:0]  index;
    logic [J2M_CDATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/j2m_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module j2m_div
    import j2m_pkg::*;
#(
    parameter int DVD_W = 20,
    parameter int DSR_W = 10
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DSR_W-1:0] dsr_reg, dsr_next;

    logic [DSR_W:0] trial;
    logic [DSR_W:0] diff;
    logic           fits;

    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/j2m_lane.sv =====
// One axis lane: maps a stick sample to a signed, accelerated motion step.
`timescale 1ns / 1ps

module j2m_lane
    import j2m_pkg::*;
#(
    parameter int ADC_MAX = J2M_ADC_MAX
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  j2m_cfg_t                cfg,
    input  j2m_lane_req_t           req,
    input  logic [J2M_SAMPLE_W-1:0] sample,
    output j2m_lane_res_t           res
);

    `include "joystick_to_mouse_motion_macros.svh"

    localparam int SMAX    = (1 << J2M_SAMPLE_W) - 1;
    localparam int R_MAX   = (SMAX * ((1 << J2M_SENS_W) - 1)) / ADC_MAX;
    localparam int R_W     = $clog2(R_MAX + 1);
    localparam int D_W     = ((R_W > J2M_SENS_W - 1) ? R_W : J2M_SENS_W - 1) + 1;
    localparam int MAG_W   = D_W - 1;
    localparam int PR_W    = J2M_SAMPLE_W + J2M_SENS_W;
    localparam int PQ_W    = MAG_W + J2M_MS_W;
    localparam int DVD_W   = PQ_W;
    localparam int DSR_W   = J2M_SENS_W;
    localparam int M_W     = DVD_W + J2M_FRAC_W;
    localparam int ACC_W   = J2M_LIM_W + J2M_ACCEL_W;

    // Division by ADC_MAX is a multiply by a rounded-up reciprocal. The shift is the
    // product width plus the ceiling of log2 of the divisor, which keeps every quotient exact.
    localparam int RCP_SH  = PR_W + $clog2(ADC_MAX);
    localparam int RCP_W   = PR_W + 2;
    localparam int RP_W    = PR_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP =
        RCP_W'(((64'd1 << RCP_SH) + 64'(ADC_MAX) - 64'd1) / 64'(ADC_MAX));

    typedef enum logic [3:0] {
        S_IDLE,
        S_R_PROD,
        S_R_MUL,
        S_AXIS,
        S_Q1_START,
        S_Q1_WAIT,
        S_Q2_START,
        S_Q2_WAIT,
        S_ACCEL,
        S_FIN,
        S_DONE
    } state_t;

    state_t                        state_reg, state_next;
    logic [J2M_SAMPLE_W-1:0]       sample_reg, sample_next;
    logic [PR_W-1:0]               pr_reg, pr_next;
    logic [R_W-1:0]                r_reg, r_next;
    logic [J2M_REPS_W-1:0]         cnt_reg, cnt_next;
    logic                          neg_reg, neg_next;
    logic                          nonzero_reg, nonzero_next;
    logic [MAG_W-1:0]              mag_reg, mag_next;
    logic [M_W-1:0]                m_reg, m_next;
    logic signed [J2M_STEP_W-1:0]  step_reg, step_next;

    logic             div_start;
    logic [DVD_W-1:0] div_dividend;
    logic [DSR_W-1:0] div_divisor;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    logic [PR_W-1:0]              prod_r;
    logic [RP_W-1:0]              prod_rcp;
    logic [PQ_W-1:0]              prod_q;
    logic [J2M_SDIV_W-1:0]        sdiv_eff;
    logic [R_W-1:0]               r_val;
    logic signed [D_W-1:0]        d_val;
    logic [D_W-1:0]               abs_d;
    logic [MAG_W-1:0]             mag_val;
    logic                         axis_zero;
    logic [J2M_LIM_W-1:0]         lim;
    logic                         m_over;
    logic [ACC_W-1:0]             acc_prod;
    logic [J2M_LIM_W-1:0]         m_clamp;
    logic [J2M_MS_W-1:0]          t_int;
    logic [J2M_STEP_W-1:0]        t_mag;

    assign prod_r   = PR_W'(sample_reg) * PR_W'(cfg.sensitivity);
    assign prod_rcp = RP_W'(pr_reg) * RP_W'(RCP);
    assign prod_q   = PQ_W'(mag_reg) * PQ_W'(cfg.max_speed);
    assign sdiv_eff = (cfg.speed_divisor == '0) ? J2M_SDIV_W'(1) : cfg.speed_divisor;

    // Axis value from the mapped reading: center, take the magnitude, apply the dead zone.
    assign r_val     = r_reg;
    assign d_val     = $signed(D_W'(r_val)) - $signed(D_W'(cfg.sensitivity[J2M_SENS_W-1:1]));
    assign abs_d     = d_val[D_W-1] ? D_W'(-d_val) : D_W'(d_val);
    assign mag_val   = abs_d[MAG_W-1:0];
    assign axis_zero = (d_val == '0) || (mag_val < MAG_W'(cfg.dead_zone));

    assign lim      = {cfg.max_speed, {J2M_FRAC_W{1'b0}}};
    assign m_over   = m_reg > M_W'(lim);
    assign acc_prod = ACC_W'(m_reg[J2M_LIM_W-1:0]) * ACC_W'(cfg.accel_base);
    assign m_clamp  = m_over ? lim : m_reg[J2M_LIM_W-1:0];
    assign t_int    = m_clamp[J2M_LIM_W-1:J2M_FRAC_W];
    assign t_mag    = (t_int == '0) ? J2M_STEP_W'(1) : J2M_STEP_W'(t_int);

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = div_quo;
        div_divisor  = DSR_W'(sdiv_eff);
        unique case (state_reg)
            S_Q1_START:
            begin
                div_start    = 1'b1;
                div_dividend = DVD_W'(prod_q);
                div_divisor  = DSR_W'(cfg.sensitivity);
            end
            S_Q2_START:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    j2m_div #(
        .DVD_W (DVD_W),
        .DSR_W (DSR_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    always_comb
    begin
        state_next   = state_reg;
        sample_next  = sample_reg;
        pr_next      = pr_reg;
        r_next       = r_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        nonzero_next = nonzero_reg;
        mag_next     = mag_reg;
        m_next       = m_reg;
        step_next    = step_reg;
        unique case (state_reg)
            S_IDLE, S_DONE:
            begin
                if (req.start)
                begin
                    sample_next = sample;
                    cnt_next    = req.reps;
                    state_next  = S_R_PROD;
                end
            end
            S_R_PROD:
            begin
                pr_next    = prod_r;
                state_next = S_R_MUL;
            end
            S_R_MUL:
            begin
                r_next     = R_W'(prod_rcp >> RCP_SH);
                state_next = S_AXIS;
            end
            S_AXIS:
            begin
                if (axis_zero)
                begin
                    nonzero_next = 1'b0;
                    step_next    = '0;
                    state_next   = S_DONE;
                end
                else
                begin
                    nonzero_next = 1'b1;
                    // The axis value is the negated centered reading.
                    neg_next     = !d_val[D_W-1];
                    mag_next     = mag_val;
                    state_next   = S_Q1_START;
                end
            end
            S_Q1_START:
            begin
                state_next = S_Q1_WAIT;
            end
            S_Q1_WAIT:
            begin
                if (div_done)
                begin
                    state_next = S_Q2_START;
                end
            end
            S_Q2_START:
            begin
                state_next = S_Q2_WAIT;
            end
            S_Q2_WAIT:
            begin
                if (div_done)
                begin
                    m_next     = {div_quo, {J2M_FRAC_W{1'b0}}};
                    state_next = S_ACCEL;
                end
            end
            S_ACCEL:
            begin
                if ((cnt_reg == '0) || m_over)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    m_next   = M_W'(acc_prod[ACC_W-1:J2M_FRAC_W]);
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_FIN:
            begin
                step_next  = neg_reg ? -$signed(t_mag) : $signed(t_mag);
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            nonzero_reg <= 1'b0;
            step_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            nonzero_reg <= nonzero_next;
            step_reg    <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        pr_reg     <= pr_next;
        r_reg      <= r_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        mag_reg    <= mag_next;
        m_reg      <= m_next;
    end

    assign res.done    = (state_reg == S_DONE);
    assign res.nonzero = nonzero_reg;
    assign res.step    = step_reg;

    `J2M_ASSERT_NEXT(a_step_nonzero, state_reg == S_FIN, step_reg != '0, "zero deflected step")
    `J2M_ASSERT_NOW(a_zero_axis, (state_reg == S_DONE) && !nonzero_reg, step_reg == '0, "nonzero idle step")
    `J2M_ASSERT_NOW(a_step_range, state_reg == S_DONE, step_reg != 8'sh80, "step out of range")

endmodule

// ===== rtl/joystick_to_mouse_motion.sv =====
// Top level of the joystick to mouse motion reporter.
`timescale 1ns / 1ps

// Takes one stick word at a time and returns at most one mouse report word for it.
// A word that arrives before the report period has elapsed is dropped, and the block
// goes from its check state straight back to idle for the next word. Otherwise both
// axes run in parallel lanes: each maps its sample with a reciprocal multiply, then
// one serial divider works out two quotients (17 bits at the default ADC_MAX) one bit
// per cycle, and then one acceleration multiply per repeat until the step passes the
// clamp. A new stick word is not taken until both lanes are done with the last one.
// The finished report waits in an output register, so the next stick word is taken
// while it is pending; a second report then holds the block until the first is taken.
module joystick_to_mouse_motion
    import j2m_pkg::*;
#(
    parameter int ADC_MAX = J2M_ADC_MAX
) (
    input logic          clk,
    input logic          rst_n,
    j2m_stick_if.sink    stick,
    j2m_report_if.source report,
    j2m_cfg_if.sink      cfg
);

    `include "joystick_to_mouse_motion_macros.svh"

    typedef enum logic [1:0] {
        T_IDLE,
        T_CHECK,
        T_RUN,
        T_MERGE
    } state_t;

    j2m_cfg_t cfg_reg;

    state_t                       state_reg, state_next;
    logic [J2M_TIME_W-1:0]        now_reg, now_next;
    logic [J2M_SAMPLE_W-1:0]      xs_reg, xs_next;
    logic [J2M_SAMPLE_W-1:0]      ys_reg, ys_next;
    logic                         pressed_reg, pressed_next;
    logic [J2M_REPS_W-1:0]        rc_reg, rc_next;
    logic [J2M_TIME_W-1:0]        last_report_reg, last_report_next;
    logic                         deb_reg, deb_next;
    logic [J2M_TIME_W-1:0]        last_btn_reg, last_btn_next;
    logic                         rpt_btn_reg, rpt_btn_next;
    logic                         out_valid_reg, out_valid_next;
    logic                         out_btn_reg, out_btn_next;
    logic signed [J2M_STEP_W-1:0] dx_reg, dx_next;
    logic signed [J2M_STEP_W-1:0] dy_reg, dy_next;

    logic [J2M_TIME_W-1:0] elapsed;
    logic [J2M_MSEC_W-1:0] period;
    logic                  period_ok;
    logic [J2M_TIME_W-1:0] btn_elapsed;
    logic                  btn_chg;
    logic                  motion;
    logic                  send;
    logic                  out_free;
    logic                  load_out;
    logic [J2M_REPS_W-1:0] rc_inc;

    j2m_lane_req_t lane_req;
    j2m_lane_res_t res_x;
    j2m_lane_res_t res_y;

    // Configuration registers; writes must only come while the block is idle, which the block itself does not enforce.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= J2M_CFG_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (j2m_reg_e'(cfg.index))
                REG_SENSITIVITY:     cfg_reg.sensitivity        <= cfg.data[J2M_SENS_W-1:0];
                REG_DEAD_ZONE:       cfg_reg.dead_zone          <= cfg.data[J2M_DZ_W-1:0];
                REG_MAX_SPEED:       cfg_reg.max_speed          <= cfg.data[J2M_MS_W-1:0];
                REG_SPEED_DIVISOR:   cfg_reg.speed_divisor      <= cfg.data[J2M_SDIV_W-1:0];
                REG_ACCEL_BASE:      cfg_reg.accel_base         <= cfg.data[J2M_ACCEL_W-1:0];
                REG_REPEAT_INTERVAL: cfg_reg.repeat_interval_ms <= cfg.data[J2M_MSEC_W-1:0];
                REG_FIRST_DELAY:     cfg_reg.first_delay_ms     <= cfg.data[J2M_MSEC_W-1:0];
                REG_DEBOUNCE:        cfg_reg.debounce_ms        <= cfg.data[J2M_MSEC_W-1:0];
                default:             cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign elapsed   = now_reg - last_report_reg;
    assign period    = (rc_reg != '0) ? cfg_reg.repeat_interval_ms : cfg_reg.first_delay_ms;
    assign period_ok = elapsed >= J2M_TIME_W'(period);
    assign rc_inc    = (rc_reg == J2M_REPS_MAX) ? rc_reg : rc_reg + 1'b1;

    assign btn_elapsed = now_reg - last_btn_reg;
    assign btn_chg     = (pressed_reg != deb_reg)
                         && (btn_elapsed > J2M_TIME_W'(cfg_reg.debounce_ms));
    assign motion      = res_x.nonzero || res_y.nonzero;
    assign send        = motion || btn_chg;
    assign out_free    = !out_valid_reg || report.ready;
    assign load_out    = (state_reg == T_MERGE) && send && out_free;

    // Lanes always get the incremented count; it only sticks when there is motion.
    assign lane_req.start = (state_reg == T_CHECK) && period_ok;
    assign lane_req.reps  = rc_inc;

    j2m_lane #(
        .ADC_MAX (ADC_MAX)
    ) u_lane_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .req    (lane_req),
        .sample (xs_reg),
        .res    (res_x)
    );

    j2m_lane #(
        .ADC_MAX (ADC_MAX)
    ) u_lane_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .req    (lane_req),
        .sample (ys_reg),
        .res    (res_y)
    );

    always_comb
    begin
        state_next       = state_reg;
        now_next         = now_reg;
        xs_next          = xs_reg;
        ys_next          = ys_reg;
        pressed_next     = pressed_reg;
        rc_next          = rc_reg;
        last_report_next = last_report_reg;
        deb_next         = deb_reg;
        last_btn_next    = last_btn_reg;
        rpt_btn_next     = rpt_btn_reg;
        out_btn_next     = out_btn_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        out_valid_next   = report.ready ? 1'b0 : out_valid_reg;
        unique case (state_reg)
            T_IDLE:
            begin
                if (stick.valid)
                begin
                    now_next     = stick.now_ms;
                    xs_next      = stick.x_sample;
                    ys_next      = stick.y_sample;
                    pressed_next = !stick.button_level;
                    state_next   = T_CHECK;
                end
            end
            T_CHECK:
            begin
                state_next = period_ok ? T_RUN : T_IDLE;
            end
            T_RUN:
            begin
                if (res_x.done && res_y.done)
                begin
                    state_next = T_MERGE;
                end
            end
            T_MERGE:
            begin
                if (!send)
                begin
                    rc_next    = '0;
                    state_next = T_IDLE;
                end
                else if (out_free)
                begin
                    rc_next          = motion ? rc_inc : '0;
                    last_report_next = now_reg;
                    if (btn_chg)
                    begin
                        deb_next      = pressed_reg;
                        last_btn_next = now_reg;
                    end
                    rpt_btn_next   = rpt_btn_reg ^ btn_chg;
                    out_btn_next   = rpt_btn_reg ^ btn_chg;
                    dx_next        = res_x.step;
                    dy_next        = res_y.step;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end
            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= T_IDLE;
            rc_reg          <= '0;
            last_report_reg <= '0;
            deb_reg         <= 1'b0;
            last_btn_reg    <= '0;
            rpt_btn_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            rc_reg          <= rc_next;
            last_report_reg <= last_report_next;
            deb_reg         <= deb_next;
            last_btn_reg    <= last_btn_next;
            rpt_btn_reg     <= rpt_btn_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg     <= now_next;
        xs_reg      <= xs_next;
        ys_reg      <= ys_next;
        pressed_reg <= pressed_next;
        out_btn_reg <= out_btn_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
    end

    assign stick.ready       = (state_reg == T_IDLE);
    assign report.valid      = out_valid_reg;
    assign report.button_bit = out_btn_reg;
    assign report.dx         = dx_reg;
    assign report.dy         = dy_reg;

    `J2M_ASSERT_NEXT(a_motion_step, load_out && motion, (dx_reg != '0) || (dy_reg != '0), "no step")
    `J2M_ASSERT_NEXT(a_repeat_set, load_out && motion, rc_reg != '0, "repeat count not advanced")
    `J2M_ASSERT_NEXT(a_skip_keeps_time, (state_reg == T_CHECK) && !period_ok, $stable(last_report_reg), "time moved")

endmodule
